### src/deq_pkg.sv
package deq_pkg;

  // operation codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_PEEK       = 3'd4
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_UNDER = 2'd1,
    STATUS_OVER  = 2'd2
  } status_e;

  localparam int unsigned DataW  = 32;
  localparam int unsigned TotalW = 5;

  localparam logic signed [DataW-1:0] EmptyValue = -32'sd1;

  // input word
  typedef struct packed {
    logic [2:0]              mode;
    logic signed [DataW-1:0] value;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] front_value;
    logic signed [DataW-1:0] back_value;
    logic [TotalW-1:0]       entry_total;
    logic                    is_empty;
  } out_word_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } cell_ctrl_t;

endpackage

### src/deq_cell.sv
module deq_cell
  import deq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic signed [DataW-1:0] left_data_i,
  input  logic                    left_valid_i,
  input  logic signed [DataW-1:0] right_data_i,
  input  logic                    right_valid_i,
  output logic signed [DataW-1:0] data_o,
  output logic                    valid_o,
  output logic                    is_back_o
);

  logic signed [DataW-1:0] data_q, data_d;
  logic                    valid_q, valid_d;

  // local update from neighbors
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    priority if (ctrl_i.push_front) begin
      data_d  = left_data_i;
      valid_d = left_valid_i;
    end else if (ctrl_i.pop_front) begin
      data_d  = right_data_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.push_back) begin
      // first free cell takes the word
      if (!valid_q && left_valid_i) begin
        data_d  = value_i;
        valid_d = 1'b1;
      end
    end else if (ctrl_i.pop_back) begin
      // last occupied cell lets go
      if (valid_q && !right_valid_i) begin
        valid_d = 1'b0;
      end
    end else begin
      // no operation this cycle, hold
      data_d  = data_q;
      valid_d = valid_q;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  assign valid_o   = valid_q;
  assign is_back_o = valid_q && !right_valid_i;

endmodule

### src/deq_chain.sv
module deq_chain
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cell_ctrl_t              ctrl_i,
  input  logic signed [DataW-1:0] value_i,
  output logic signed [DataW-1:0] front_o,
  output logic signed [DataW-1:0] back_o,
  output logic                    empty_o
);

  logic signed [DataW-1:0] data  [DEPTH];
  logic                    valid [DEPTH];
  logic [DEPTH-1:0]        is_back;

  // row of cells, front entry always in cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DataW-1:0] left_data;
    logic                    left_valid;
    logic signed [DataW-1:0] right_data;
    logic                    right_valid;

    if (i == 0) begin : g_head
      assign left_data  = value_i;
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = data[i-1];
      assign left_valid = valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = data[i+1];
      assign right_valid = valid[i+1];
    end

    deq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .value_i       (value_i),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (data[i]),
      .valid_o       (valid[i]),
      .is_back_o     (is_back[i])
    );
  end

  // back entry picked by the one-hot tail marker
  always_comb begin
    back_o = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_o = back_o | (data[i] & {DataW{is_back[i]}});
    end
  end

  assign front_o = data[0];
  assign empty_o = !valid[0];

endmodule

### src/double_ended_queue_top.sv
// an accepted input word updates the cell row, entry count and status register; ST_REPLY then
// registers the result word, read from the updated row through the back-entry select; no new
// input word is taken until that is done, and ST_REPLY waits while an unread result word is held
// reset: the cell occupancy flags, entry count and handshake state clear at once;
// stored entries keep whatever they held and are never read before a push
module double_ended_queue_top
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int unsigned CountW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_REPLY = 2'b10
  } state_e;

  state_e                  state_q, state_d;
  logic [CountW-1:0]       count_q, count_d;
  logic [1:0]              status_q, status_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_q, out_d;
  cell_ctrl_t              ctrl;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic signed [DataW-1:0] front_val;
  logic signed [DataW-1:0] back_val;
  logic                    row_empty;
  logic [CountW+TotalW-1:0] count_ext;

  assign accept = in_valid_i && in_ready_o;
  assign full   = (count_q == CountW'(DEPTH));
  assign empty  = (count_q == '0);

  // decode the operation into a row command
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = status_q;
    if (accept) begin
      status_d = STATUS_OK;
      unique case (in_word_i.mode)
        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
          if (full) begin
            status_d = STATUS_OVER;
          end else begin
            ctrl.push_front = (in_word_i.mode == MODE_PUSH_FRONT);
            ctrl.push_back  = (in_word_i.mode == MODE_PUSH_BACK);
            count_d         = count_q + 1'b1;
          end
        end
        MODE_POP_FRONT, MODE_POP_BACK: begin
          if (empty) begin
            status_d = STATUS_UNDER;
          end else begin
            ctrl.pop_front = (in_word_i.mode == MODE_POP_FRONT);
            ctrl.pop_back  = (in_word_i.mode == MODE_POP_BACK);
            count_d        = count_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  deq_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .value_i (in_word_i.value),
    .front_o (front_val),
    .back_o  (back_val),
    .empty_o (row_empty)
  );

  assign count_ext = (CountW + TotalW)'(count_q);

  // result word and handshake sequencing
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_REPLY;
        end
      end
      ST_REPLY: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status      = status_q;
          out_d.front_value = row_empty ? EmptyValue : front_val;
          out_d.back_value  = row_empty ? EmptyValue : back_val;
          out_d.entry_total = count_ext[TotalW-1:0];
          out_d.is_empty    = row_empty;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
